>>> design/iss_pkg.sv
// Package for the interpolation search block: sizes, types and the
// command/status structs shared by controller and datapath. No dependencies.
package iss_pkg;
   localparam int Depth      = 1024;
   localparam int AddrWidth  = 10;
   localparam int ValueWidth = 32;
   localparam int CountWidth = 11;
   localparam int QuotWidth  = 32;

   localparam logic CmdWrite  = 1'b0;
   localparam logic CmdSearch = 1'b1;

   typedef logic [AddrWidth-1:0]  addr_type;
   typedef logic [ValueWidth-1:0] value_type;

   typedef struct packed {
      logic     start;      // load key and bounds for a new search
      logic     ram_rd;     // read RAM at rd_addr
      logic [1:0] rd_sel;   // which register gets the read data
      logic     div_start;  // begin the quotient
      logic     div_step;   // one quotient bit
      logic     set_probe;  // p = l + quotient (or l when flat)
      logic     narrow;     // update l or h from a[p]
   } dp_cmd_type;

   typedef struct packed {
      logic     empty;      // range l..h is empty
      logic     out_bounds; // key outside a[l]..a[h]
      logic     flat;       // a[h] == a[l]
      logic     hit;        // a[p] == key
      logic     div_done;
   } dp_sts_type;

   localparam logic [1:0] SelLo = 2'd0;
   localparam logic [1:0] SelHi = 2'd1;
   localparam logic [1:0] SelPr = 2'd2;
endpackage

>>> design/iss_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module iss_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

>>> design/iss_datapath.sv
// Datapath for the interpolation search: bounds, key, table reads and a
// bit-serial scaled quotient. Uses iss_pkg and iss_ram.
module iss_datapath (
   input  logic                    clock,
   input  logic                    wr_en,
   input  iss_pkg::addr_type       wr_addr,
   input  iss_pkg::value_type      wr_data,
   input  iss_pkg::value_type      key_in,
   input  logic [iss_pkg::CountWidth-1:0] count,
   input  iss_pkg::dp_cmd_type     cmd,
   output iss_pkg::dp_sts_type     sts,
   output iss_pkg::addr_type       probe
);
   import iss_pkg::*;

   // Values are kept biased (sign bit flipped) so unsigned compare is signed order.
   value_type key_ff, al_ff, ah_ff, ap_ff, rd_data;
   logic signed [CountWidth:0] l_ff, h_ff;
   addr_type p_ff, rd_addr;
   logic [1:0] sel_ff;
   logic [ValueWidth:0] r_ff, den_ff, d_ff;
   logic [QuotWidth-1:0] q_ff;
   logic [AddrWidth:0] m_ff;
   logic [5:0] bit_ff;
   logic [CountWidth-1:0] n;

   iss_ram #(.Width(ValueWidth), .Depth(Depth)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign n = (count > CountWidth'(Depth)) ? CountWidth'(Depth) : count;

   always_comb begin
      unique case (cmd.rd_sel)
         SelLo:   rd_addr = l_ff[AddrWidth-1:0];
         SelHi:   rd_addr = h_ff[AddrWidth-1:0];
         default: rd_addr = p_ff;
      endcase
   end

   logic [ValueWidth:0] r2, rs, den_m_d;
   logic                q_bit1, q_bit2;
   logic [ValueWidth:0] r_next;
   logic [AddrWidth:0]  m_sh;
   always_comb begin
      q_bit1 = r_ff >= (den_ff - r_ff);
      r2 = q_bit1 ? (r_ff - (den_ff - r_ff)) : (r_ff << 1);
      den_m_d = den_ff - d_ff;
      q_bit2 = 1'b0;
      rs = r2;
      // Bits of the multiplier above its width shift out as zero.
      m_sh = m_ff >> bit_ff;
      if (m_sh[0]) begin
         if (r2 >= den_m_d) begin
            rs = r2 - den_m_d;
            q_bit2 = 1'b1;
         end else begin
            rs = r2 + d_ff;
         end
      end
      r_next = rs;
   end

   always_ff @(posedge clock) begin
      sel_ff <= cmd.rd_sel;
      if (cmd.start) begin
         key_ff <= {~key_in[ValueWidth-1], key_in[ValueWidth-2:0]};
         l_ff   <= '0;
         h_ff   <= $signed({1'b0, n} - {{CountWidth{1'b0}}, 1'b1});
      end
      if (cmd.ram_rd) begin
         // Data arrives in the next cycle; capture uses the select of that read.
      end
      if (cmd.div_start) begin
         r_ff   <= '0;
         q_ff   <= '0;
         den_ff <= {1'b0, ah_ff - al_ff};
         d_ff   <= {1'b0, key_ff - al_ff};
         m_ff   <= (AddrWidth+1)'(h_ff - l_ff);
         bit_ff <= 6'(QuotWidth-1);
      end else if (cmd.div_step) begin
         r_ff   <= r_next;
         q_ff   <= (q_ff << 1) + {{(QuotWidth-1){1'b0}}, q_bit1} +
                   {{(QuotWidth-1){1'b0}}, q_bit2};
         bit_ff <= bit_ff - 6'd1;
      end
      if (cmd.set_probe) begin
         p_ff <= sts.flat ? l_ff[AddrWidth-1:0]
                          : AddrWidth'(l_ff[AddrWidth-1:0] + q_ff[AddrWidth-1:0]);
      end
      if (cmd.narrow) begin
         if (ap_ff < key_ff) l_ff <= $signed({2'b00, p_ff} + {{CountWidth{1'b0}}, 1'b1});
         else                h_ff <= $signed({2'b00, p_ff} - {{CountWidth{1'b0}}, 1'b1});
      end
   end

   // Registered read data lands in the register chosen by the last select.
   logic rd_vld_ff;
   always_ff @(posedge clock) begin
      rd_vld_ff <= cmd.ram_rd;
      if (rd_vld_ff) begin
         unique case (sel_ff)
            SelLo:   al_ff <= {~rd_data[ValueWidth-1], rd_data[ValueWidth-2:0]};
            SelHi:   ah_ff <= {~rd_data[ValueWidth-1], rd_data[ValueWidth-2:0]};
            default: ap_ff <= {~rd_data[ValueWidth-1], rd_data[ValueWidth-2:0]};
         endcase
      end
   end

   assign sts.empty      = l_ff > h_ff;
   assign sts.out_bounds = (key_ff < al_ff) || (key_ff > ah_ff);
   assign sts.flat       = ah_ff == al_ff;
   assign sts.hit        = ap_ff == key_ff;
   assign sts.div_done   = bit_ff == 6'd0;
   assign probe          = p_ff;
endmodule

>>> design/iss_ctrl.sv
// Controller for the interpolation search: accepts beats, sequences reads,
// the quotient and the narrowing, and holds the result. Uses iss_pkg.
module iss_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_cmd,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_found,
   output iss_pkg::addr_type   rsp_pos,
   output logic                wr_en,
   output iss_pkg::dp_cmd_type cmd,
   input  iss_pkg::dp_sts_type sts,
   input  iss_pkg::addr_type   probe
);
   import iss_pkg::*;

   localparam logic [3:0] StIdle = 4'd0, StCheck = 4'd1, StRdLo = 4'd2,
      StRdHi = 4'd3, StWait = 4'd4, StBound = 4'd5, StDiv = 4'd6,
      StProbe = 4'd7, StRdP = 4'd8, StWaitP = 4'd9, StCmp = 4'd10,
      StDone = 4'd11, StWait2 = 4'd12, StWaitP2 = 4'd13;

   logic [3:0] state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in, found_ff, found_in;
   addr_type pos_ff, pos_in;

   assign req_ready = (state_ff == StIdle) && !rsp_valid_ff;
   assign wr_en     = req_valid && req_ready && (req_cmd == CmdWrite);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = found_ff;
   assign rsp_pos   = pos_ff;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      found_in = found_ff;
      pos_in = pos_ff;
      cmd = '0;
      cmd.rd_sel = SelLo;
      unique case (state_ff)
         StIdle: if (req_valid && req_ready && req_cmd == CmdSearch) begin
            cmd.start = 1'b1;
            state_in = StCheck;
         end
         StCheck: state_in = sts.empty ? StDone : StRdLo;
         StRdLo: begin
            cmd.ram_rd = 1'b1;
            state_in = StRdHi;
         end
         StRdHi: begin
            cmd.ram_rd = 1'b1;
            cmd.rd_sel = SelHi;
            state_in = StWait;
         end
         StWait:  state_in = StWait2;
         StWait2: state_in = StBound;
         StBound: begin
            if (sts.out_bounds) state_in = StDone;
            else begin
               cmd.div_start = 1'b1;
               state_in = sts.flat ? StProbe : StDiv;
            end
         end
         StDiv: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = StProbe;
         end
         StProbe: begin
            cmd.set_probe = 1'b1;
            state_in = StRdP;
         end
         StRdP: begin
            cmd.ram_rd = 1'b1;
            cmd.rd_sel = SelPr;
            state_in = StWaitP;
         end
         StWaitP:  state_in = StWaitP2;
         StWaitP2: state_in = StCmp;
         StCmp: begin
            if (sts.hit) begin
               found_in = 1'b1;
               pos_in = probe;
               rsp_valid_in = 1'b1;
               state_in = StIdle;
            end else begin
               cmd.narrow = 1'b1;
               state_in = StCheck;
            end
         end
         StDone: begin
            found_in = 1'b0;
            pos_in = '0;
            rsp_valid_in = 1'b1;
            state_in = StIdle;
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      found_ff <= found_in;
      pos_ff <= pos_in;
   end

`ifndef SYNTH
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != StIdle) |-> !req_ready) else $error("accept while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(pos_ff)))
      else $error("result dropped");
   a_miss_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !found_ff) |-> (pos_ff == '0)) else $error("miss position");
`endif
endmodule

>>> design/interpolation_search_sorted_table.sv
// Top level of the interpolation search over a stored table.
// Uses iss_pkg, iss_ctrl and iss_datapath.
//
// Usage: req_ beats carry either a table write (req_tuser 0) or a search
// (req_tuser 1). A write gives no result beat. A search gives one rsp_
// beat with found and position. The csr_ channel sets entry_count; the user
// must write it only while the block is idle, which the block does not enforce.
// Each search probe reads the low and high bounds, builds the scaled
// quotient one bit a cycle and reads the probed entry; a flat range
// probe skips the quotient. A miss answers when the range empties or
// the key falls out of bounds; an empty table answers without reads.
// One item is in work at a time; a finished result waits in the output
// register and no new beat is taken until it has left.
// Reset clears the controller and entry_count; table contents stay
// undefined until written.
// When the receiver stalls, the result holds on rsp_tdata until taken.
module interpolation_search_sorted_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // cmd
   input  logic [79:0] req_tdata,   // index[9:0], entry_value, search_key, zero fill
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_data,    // entry_count
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // found, position[9:0], zero fill
);
   import iss_pkg::*;

   logic [CountWidth-1:0] count_ff;
   dp_cmd_type cmd;
   dp_sts_type sts;
   addr_type probe, pos;
   logic wr_en, found;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else if (csr_valid) count_ff <= csr_data;
   end

   iss_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_tvalid), .req_cmd(req_tuser),
      .req_ready(req_tready), .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready),
      .rsp_found(found), .rsp_pos(pos), .wr_en(wr_en), .cmd(cmd), .sts(sts),
      .probe(probe)
   );

   iss_datapath u_dp (
      .clock(clock), .wr_en(wr_en), .wr_addr(req_tdata[9:0]),
      .wr_data(req_tdata[41:10]), .key_in(req_tdata[73:42]), .count(count_ff),
      .cmd(cmd), .sts(sts), .probe(probe)
   );

   assign rsp_tdata = {5'd0, pos, found};
endmodule
